// ----- design/lzsd_pkg.sv -----
// Shared types and constants of the LZS window decoder.
package lzsd_pkg;

  localparam int WINDOW_DEPTH = 2048;
  localparam int WIN_AW       = $clog2(WINDOW_DEPTH);
  localparam logic [31:0] LIMIT_RESET = 32'd65536;

  // result status codes
  localparam logic [1:0] ST_DATA  = 2'd0;
  localparam logic [1:0] ST_END   = 2'd1;
  localparam logic [1:0] ST_ERR   = 2'd2;
  localparam logic [1:0] ST_INEND = 2'd3;

  // configuration register byte addresses
  localparam logic [2:0] ADDR_OUTPUT_LIMIT = 3'd0;

  // token decode phase
  typedef enum logic [7:0] {
    PH_FLAG   = 8'b0000_0001,
    PH_LIT    = 8'b0000_0010,
    PH_SEL    = 8'b0000_0100,
    PH_SHORT  = 8'b0000_1000,
    PH_LONGHI = 8'b0001_0000,
    PH_LONGLO = 8'b0010_0000,
    PH_LEN    = 8'b0100_0000,
    PH_EXT    = 8'b1000_0000
  } phase_t;

  // sequencer state
  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_BIT   = 8'b0000_0010,
    S_LIT   = 8'b0000_0100,
    S_RES   = 8'b0000_1000,
    S_CPRD  = 8'b0001_0000,
    S_CPWR  = 8'b0010_0000,
    S_DONE  = 8'b0100_0000,
    S_FLUSH = 8'b1000_0000
  } seq_state_t;

  // sequencer to output stage
  typedef struct packed {
    logic       push;
    logic       flush;
    logic [7:0] data;
    logic [1:0] status;
  } res_ctl_t;

  // output stage to sequencer
  typedef struct packed {
    logic can_push;
    logic pend_valid;
  } res_sts_t;

endpackage

// ----- design/lzs_window_decoder.sv -----
// LZS window decoder top level: configuration register, sequencer, window, result stage.
//
// Input channel (in_valid/in_ready, in_byte, in_last) takes one compressed byte per
// item; its bits are decoded most significant first. Result channel (out_valid/out_ready,
// out_byte, out_status, out_last) gives zero or more results per input item; out_last
// marks the last result caused by that item.
// An item passes through the bit sequencer as accept, eight bit steps, end step and
// hand-off, plus a literal step per literal byte, a result step per status result, and
// per copied byte a read and a write step, plus a closing step per copy run: the window
// read is registered, so each byte is read in S_CPRD and written in S_CPWR.
// Once a stream is finished the remaining bits of the item are skipped.
// The next item is accepted only once the sequencer is idle again; the last result of
// an item may still sit in the output register meanwhile.
// A result is held one slot deep until the next result or the item's end shows
// whether it is the last one.
// When out_ready is low the sequencer waits at its next result; nothing is lost.
// Reset (rst_n low, synchronous) empties the result stage, starts a new stream and
// sets output_limit to 65536; the window needs no clearing pass, because a
// never-written entry is recognized from the produced byte count.
// The user must write output_limit (APB byte address 0) only while idle; not enforced.
module lzs_window_decoder import lzsd_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_byte,
  input  logic        in_last,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_byte,
  output logic [1:0]  out_status,
  output logic        out_last,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [31:0]       limit_r;
  logic              ram_wr_en;
  logic [WIN_AW-1:0] ram_wr_addr;
  logic [7:0]        ram_wr_data;
  logic              ram_rd_en;
  logic [WIN_AW-1:0] ram_rd_addr;
  logic [7:0]        ram_rd_data;
  res_ctl_t          ctl;
  res_sts_t          sts;

  assign pready = 1'b1;
  assign prdata = (paddr == ADDR_OUTPUT_LIMIT) ? limit_r : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= LIMIT_RESET;
    end else if (psel && penable && pwrite && paddr == ADDR_OUTPUT_LIMIT) begin
      limit_r <= pwdata;
    end
  end

  lzsd_seq u_seq (
    .clk          (clk),
    .rst_n        (rst_n),
    .output_limit (limit_r),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_byte      (in_byte),
    .in_last      (in_last),
    .ram_wr_en    (ram_wr_en),
    .ram_wr_addr  (ram_wr_addr),
    .ram_wr_data  (ram_wr_data),
    .ram_rd_en    (ram_rd_en),
    .ram_rd_addr  (ram_rd_addr),
    .ram_rd_data  (ram_rd_data),
    .ctl          (ctl),
    .sts          (sts)
  );

  lzsd_hist_ram u_ram (
    .clk       (clk),
    .wr_en     (ram_wr_en),
    .wr_addr   (ram_wr_addr),
    .wr_data   (ram_wr_data),
    .rd_en     (ram_rd_en),
    .rd_addr   (ram_rd_addr),
    .rd_data_r (ram_rd_data)
  );

  lzsd_out_stage u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctl        (ctl),
    .sts        (sts),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_byte   (out_byte),
    .out_status (out_status),
    .out_last   (out_last)
  );

  // an accepted item keeps the sequencer busy in the next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("in_ready high right after an item was accepted");

  // no result may be left pending once the sequencer is idle
  a_idle_drained: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> !sts.pend_valid)
    else $error("pending result left behind at item end");

  // status results carry a zero byte
  a_status_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_DATA |-> out_byte == 8'd0)
    else $error("nonzero byte on a status result");

  // the window is only written when a data result is pushed
  a_write_with_push: assert property (@(posedge clk) disable iff (!rst_n)
    ram_wr_en |-> ctl.push && ctl.status == ST_DATA)
    else $error("window write without a data result");

endmodule

// ----- design/lzsd_hist_ram.sv -----
// History window memory: one write port, one registered read port.
module lzsd_hist_ram import lzsd_pkg::*; (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [WIN_AW-1:0] wr_addr,
  input  logic [7:0]        wr_data,
  input  logic              rd_en,
  input  logic [WIN_AW-1:0] rd_addr,
  output logic [7:0]        rd_data_r
);

  logic [7:0] mem [WINDOW_DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

endmodule

// ----- design/lzsd_out_stage.sv -----
// Result staging: a pending slot that learns out_last, then the output register.
module lzsd_out_stage import lzsd_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  res_ctl_t   ctl,
  output res_sts_t   sts,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic [1:0] out_status,
  output logic       out_last
);

  logic       pend_valid_r, pend_valid_nxt;
  logic [7:0] pend_data_r, pend_data_nxt;
  logic [1:0] pend_st_r, pend_st_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic [7:0] out_data_r, out_data_nxt;
  logic [1:0] out_st_r, out_st_nxt;
  logic       out_last_r, out_last_nxt;
  logic       out_free;

  assign out_free     = !out_valid_r || out_ready;
  assign sts.can_push = !pend_valid_r || out_free;
  assign sts.pend_valid = pend_valid_r;

  always_comb begin
    pend_valid_nxt = pend_valid_r;
    pend_data_nxt  = pend_data_r;
    pend_st_nxt    = pend_st_r;
    out_valid_nxt  = out_valid_r;
    out_data_nxt   = out_data_r;
    out_st_nxt     = out_st_r;
    out_last_nxt   = out_last_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    // a new result proves the pending one is not the item's last
    if (ctl.push) begin
      if (pend_valid_r) begin
        out_valid_nxt = 1'b1;
        out_data_nxt  = pend_data_r;
        out_st_nxt    = pend_st_r;
        out_last_nxt  = 1'b0;
      end
      pend_valid_nxt = 1'b1;
      pend_data_nxt  = ctl.data;
      pend_st_nxt    = ctl.status;
    end else if (ctl.flush && pend_valid_r && out_free) begin
      out_valid_nxt  = 1'b1;
      out_data_nxt   = pend_data_r;
      out_st_nxt     = pend_st_r;
      out_last_nxt   = 1'b1;
      pend_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      pend_valid_r <= pend_valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pend_data_r <= pend_data_nxt;
    pend_st_r   <= pend_st_nxt;
    out_data_r  <= out_data_nxt;
    out_st_r    <= out_st_nxt;
    out_last_r  <= out_last_nxt;
  end

  assign out_valid  = out_valid_r;
  assign out_byte   = out_data_r;
  assign out_status = out_st_r;
  assign out_last   = out_last_r;

endmodule

// ----- design/lzsd_seq.sv -----
// Bit-serial token sequencer: walks one input byte bit by bit and drives literals, copies and status results.
module lzsd_seq import lzsd_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [31:0]       output_limit,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [7:0]        in_byte,
  input  logic              in_last,
  output logic              ram_wr_en,
  output logic [WIN_AW-1:0] ram_wr_addr,
  output logic [7:0]        ram_wr_data,
  output logic              ram_rd_en,
  output logic [WIN_AW-1:0] ram_rd_addr,
  input  logic [7:0]        ram_rd_data,
  output res_ctl_t          ctl,
  input  res_sts_t          sts
);

  seq_state_t        state_r, state_nxt;
  phase_t            phase_r, phase_nxt;
  logic [2:0]        bit_idx_r, bit_idx_nxt;
  logic [7:0]        byte_r, byte_nxt;
  logic              last_r, last_nxt;
  logic [10:0]       fb_r, fb_nxt;
  logic [3:0]        fc_r, fc_nxt;
  logic [WIN_AW-1:0] off_r, off_nxt;
  logic              fin_r, fin_nxt;
  logic [WIN_AW-1:0] wp_r, wp_nxt;
  logic [31:0]       prod_r, prod_nxt;
  logic [3:0]        cnt_r, cnt_nxt;
  logic [7:0]        lit_r, lit_nxt;
  logic [1:0]        res_st_r, res_st_nxt;

  logic              bit_v;
  logic [10:0]       fb_take;
  logic [3:0]        fc_inc;
  logic              at_limit;
  logic [WIN_AW-1:0] cand_off;
  logic              off_bad;
  seq_state_t        adv_state;
  logic [2:0]        adv_idx;
  logic              win_unfilled;
  logic [7:0]        cp_byte;

  assign bit_v    = byte_r[bit_idx_r];
  assign fb_take  = {fb_r[9:0], bit_v};
  assign fc_inc   = fc_r + 4'd1;
  assign at_limit = prod_r >= output_limit;
  assign cand_off = (phase_r == PH_SHORT) ? {4'd0, fb_take[6:0]} : fb_take;
  assign off_bad  = {21'd0, cand_off} > prod_r;
  assign adv_state = (bit_idx_r == 3'd0) ? S_DONE : S_BIT;
  assign adv_idx   = bit_idx_r - 3'd1;
  // the entry at the write pointer reads as zero until the window wraps
  assign win_unfilled = (prod_r[31:WIN_AW] == '0);
  assign cp_byte = (off_r == '0 && win_unfilled) ? 8'd0 : ram_rd_data;
  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt   = state_r;
    phase_nxt   = phase_r;
    bit_idx_nxt = bit_idx_r;
    byte_nxt    = byte_r;
    last_nxt    = last_r;
    fb_nxt      = fb_r;
    fc_nxt      = fc_r;
    off_nxt     = off_r;
    fin_nxt     = fin_r;
    wp_nxt      = wp_r;
    prod_nxt    = prod_r;
    cnt_nxt     = cnt_r;
    lit_nxt     = lit_r;
    res_st_nxt  = res_st_r;
    ram_wr_en   = 1'b0;
    ram_wr_addr = wp_r;
    ram_wr_data = lit_r;
    ram_rd_en   = 1'b0;
    ram_rd_addr = wp_r - off_r;
    ctl.push    = 1'b0;
    ctl.flush   = 1'b0;
    ctl.data    = 8'd0;
    ctl.status  = ST_DATA;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          byte_nxt    = in_byte;
          last_nxt    = in_last;
          bit_idx_nxt = 3'd7;
          state_nxt   = S_BIT;
        end
      end

      S_BIT: begin
        if (fin_r) begin
          state_nxt = S_DONE;
        end else begin
          state_nxt   = adv_state;
          bit_idx_nxt = adv_idx;
          unique case (phase_r)
            PH_FLAG: begin
              if (at_limit) begin
                fin_nxt = 1'b1;
              end else begin
                fb_nxt    = '0;
                fc_nxt    = '0;
                phase_nxt = bit_v ? PH_SEL : PH_LIT;
              end
            end
            PH_LIT: begin
              fb_nxt = fb_take;
              fc_nxt = fc_inc;
              if (fc_inc == 4'd8) begin
                lit_nxt     = fb_take[7:0];
                phase_nxt   = PH_FLAG;
                state_nxt   = S_LIT;
                bit_idx_nxt = bit_idx_r;
              end
            end
            PH_SEL: begin
              fb_nxt    = '0;
              fc_nxt    = '0;
              phase_nxt = bit_v ? PH_SHORT : PH_LONGHI;
            end
            PH_SHORT, PH_LONGLO: begin
              fb_nxt = fb_take;
              fc_nxt = fc_inc;
              if ((phase_r == PH_SHORT && fc_inc == 4'd7) ||
                  (phase_r == PH_LONGLO && fc_inc == 4'd11)) begin
                off_nxt = cand_off;
                if (off_bad) begin
                  res_st_nxt  = ST_ERR;
                  state_nxt   = S_RES;
                  bit_idx_nxt = bit_idx_r;
                end else begin
                  fb_nxt    = '0;
                  fc_nxt    = '0;
                  phase_nxt = PH_LEN;
                end
              end
            end
            PH_LONGHI: begin
              fb_nxt = fb_take;
              fc_nxt = fc_inc;
              if (fc_inc == 4'd7) begin
                if (fb_take[6:0] == 7'd0) begin
                  res_st_nxt  = ST_END;
                  state_nxt   = S_RES;
                  bit_idx_nxt = bit_idx_r;
                end else begin
                  phase_nxt = PH_LONGLO;
                end
              end
            end
            PH_LEN: begin
              fb_nxt = fb_take;
              fc_nxt = fc_inc;
              if (fc_inc == 4'd2 && fb_take[1:0] != 2'd3) begin
                cnt_nxt     = fb_take[3:0] + 4'd2;
                phase_nxt   = PH_FLAG;
                state_nxt   = S_CPRD;
                bit_idx_nxt = bit_idx_r;
              end else if (fc_inc == 4'd4) begin
                cnt_nxt     = {2'd0, fb_take[1:0]} + 4'd5;
                fb_nxt      = '0;
                fc_nxt      = '0;
                phase_nxt   = (fb_take[1:0] == 2'd3) ? PH_EXT : PH_FLAG;
                state_nxt   = S_CPRD;
                bit_idx_nxt = bit_idx_r;
              end
            end
            PH_EXT: begin
              fb_nxt = fb_take;
              fc_nxt = fc_inc;
              if (fc_inc == 4'd4) begin
                cnt_nxt     = fb_take[3:0];
                fb_nxt      = '0;
                fc_nxt      = '0;
                phase_nxt   = (fb_take[3:0] == 4'hF) ? PH_EXT : PH_FLAG;
                state_nxt   = S_CPRD;
                bit_idx_nxt = bit_idx_r;
              end
            end
            default: begin
              phase_nxt = PH_FLAG;
            end
          endcase
        end
      end

      S_LIT: begin
        if (at_limit) begin
          state_nxt   = adv_state;
          bit_idx_nxt = adv_idx;
        end else if (sts.can_push) begin
          ram_wr_en   = 1'b1;
          ram_wr_data = lit_r;
          ctl.push    = 1'b1;
          ctl.data    = lit_r;
          ctl.status  = ST_DATA;
          wp_nxt      = wp_r + WIN_AW'(1);
          prod_nxt    = prod_r + 32'd1;
          state_nxt   = adv_state;
          bit_idx_nxt = adv_idx;
        end
      end

      S_RES: begin
        if (sts.can_push) begin
          ctl.push    = 1'b1;
          ctl.status  = res_st_r;
          fin_nxt     = 1'b1;
          state_nxt   = adv_state;
          bit_idx_nxt = adv_idx;
        end
      end

      S_CPRD: begin
        if (cnt_r == 4'd0 || at_limit) begin
          state_nxt   = adv_state;
          bit_idx_nxt = adv_idx;
        end else begin
          ram_rd_en = 1'b1;
          state_nxt = S_CPWR;
        end
      end

      S_CPWR: begin
        if (sts.can_push) begin
          ram_wr_en   = 1'b1;
          ram_wr_data = cp_byte;
          ctl.push    = 1'b1;
          ctl.data    = cp_byte;
          ctl.status  = ST_DATA;
          wp_nxt      = wp_r + WIN_AW'(1);
          prod_nxt    = prod_r + 32'd1;
          cnt_nxt     = cnt_r - 4'd1;
          state_nxt   = S_CPRD;
        end
      end

      S_DONE: begin
        if (!last_r) begin
          state_nxt = S_FLUSH;
        end else if (fin_r || sts.can_push) begin
          ctl.push   = !fin_r;
          ctl.status = ST_INEND;
          // stream ends: start the next one from scratch
          wp_nxt     = '0;
          prod_nxt   = '0;
          phase_nxt  = PH_FLAG;
          fb_nxt     = '0;
          fc_nxt     = '0;
          off_nxt    = '0;
          fin_nxt    = 1'b0;
          state_nxt  = S_FLUSH;
        end
      end

      S_FLUSH: begin
        ctl.flush = 1'b1;
        if (sts.can_push) begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      phase_r <= PH_FLAG;
      fb_r    <= '0;
      fc_r    <= '0;
      off_r   <= '0;
      fin_r   <= 1'b0;
      wp_r    <= '0;
      prod_r  <= '0;
    end else begin
      state_r <= state_nxt;
      phase_r <= phase_nxt;
      fb_r    <= fb_nxt;
      fc_r    <= fc_nxt;
      off_r   <= off_nxt;
      fin_r   <= fin_nxt;
      wp_r    <= wp_nxt;
      prod_r  <= prod_nxt;
    end
  end

  always_ff @(posedge clk) begin
    bit_idx_r <= bit_idx_nxt;
    byte_r    <= byte_nxt;
    last_r    <= last_nxt;
    cnt_r     <= cnt_nxt;
    lit_r     <= lit_nxt;
    res_st_r  <= res_st_nxt;
  end

endmodule
